/* rtl/core/sqs_pkg.sv */
// Shared types and constants for the Sunday quick search matcher.
`default_nettype none
package sqs_pkg;

  localparam int PATTERN_MAX = 64;
  localparam int TEXT_MAX    = 4096;

  localparam int PAT_AW  = $clog2(PATTERN_MAX);
  localparam int TXT_AW  = $clog2(TEXT_MAX);
  localparam int PLEN_W  = PAT_AW + 1;
  localparam int TLEN_W  = TXT_AW + 1;
  localparam int SYM_W   = 8;
  localparam int ALPHA   = 256;
  localparam int OP_W    = 2;
  localparam int POS_W   = 12;
  localparam int CNT_W   = 19;
  localparam int OUT_W   = 1 + POS_W + 1 + CNT_W + 1;
  localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8;

  typedef enum logic [OP_W-1:0] {
    OP_CLEAR    = 2'd0,
    OP_APP_PAT  = 2'd1,
    OP_APP_TXT  = 2'd2,
    OP_FIND     = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WIN,
    ST_START,
    ST_CHECK,
    ST_PAST,
    ST_LOOK,
    ST_SHIFT,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic clear;
    logic app_pat;
    logic app_txt;
    logic find;
    logic fetch_first;
    logic fetch_next;
    logic check;
    logic fetch_past;
    logic shift;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic win_ok;
    logic eq;
    logic last;
    logic hit;
    logic out_free;
  } stat_t;

endpackage
`default_nettype wire

/* rtl/core/sqs_ctrl.sv */
// Controller state machine for the Sunday quick search matcher.
`default_nettype none
module sqs_ctrl (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_tvalid,
  output logic                            in_tready,
  input  wire logic [sqs_pkg::OP_W-1:0]   op,
  input  wire sqs_pkg::stat_t             stat,
  output sqs_pkg::cmd_t                   cmd
);

  sqs_pkg::state_t state_r;
  sqs_pkg::state_t state_nxt;
  logic            accept;

  assign in_tready = (state_r == sqs_pkg::ST_IDLE);
  assign accept    = in_tvalid & in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sqs_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      sqs_pkg::ST_IDLE: begin
        if (accept && (op == sqs_pkg::OP_FIND)) begin
          state_nxt = sqs_pkg::ST_WIN;
        end
      end
      sqs_pkg::ST_WIN: begin
        if (stat.hit || !stat.win_ok) begin
          state_nxt = sqs_pkg::ST_EMIT;
        end else begin
          state_nxt = sqs_pkg::ST_START;
        end
      end
      sqs_pkg::ST_START: begin
        state_nxt = sqs_pkg::ST_CHECK;
      end
      sqs_pkg::ST_CHECK: begin
        if (!stat.eq || stat.last) begin
          state_nxt = sqs_pkg::ST_PAST;
        end
      end
      sqs_pkg::ST_PAST:  state_nxt = sqs_pkg::ST_LOOK;
      sqs_pkg::ST_LOOK:  state_nxt = sqs_pkg::ST_SHIFT;
      sqs_pkg::ST_SHIFT: state_nxt = sqs_pkg::ST_WIN;
      sqs_pkg::ST_EMIT: begin
        if (stat.out_free) begin
          state_nxt = sqs_pkg::ST_IDLE;
        end
      end
      default: state_nxt = sqs_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    case (state_r)
      sqs_pkg::ST_IDLE: begin
        cmd.clear   = accept && (op == sqs_pkg::OP_CLEAR);
        cmd.app_pat = accept && (op == sqs_pkg::OP_APP_PAT);
        cmd.app_txt = accept && (op == sqs_pkg::OP_APP_TXT);
        cmd.find    = accept && (op == sqs_pkg::OP_FIND);
      end
      sqs_pkg::ST_START: cmd.fetch_first = 1'b1;
      sqs_pkg::ST_CHECK: begin
        cmd.check      = 1'b1;
        cmd.fetch_next = stat.eq && !stat.last;
      end
      sqs_pkg::ST_PAST:  cmd.fetch_past = 1'b1;
      sqs_pkg::ST_SHIFT: cmd.shift      = 1'b1;
      sqs_pkg::ST_EMIT:  cmd.emit       = stat.out_free;
      default: cmd = '0;
    endcase
  end

endmodule
`default_nettype wire

/* rtl/core/sqs_dpath.sv */
// Datapath of the matcher: stores, occurrence table, counters and result register.
`default_nettype none
module sqs_dpath (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic [sqs_pkg::SYM_W-1:0]          symbol,
  input  wire sqs_pkg::cmd_t                      cmd,
  output sqs_pkg::stat_t                          stat,
  output logic                                    out_tvalid,
  input  wire logic                               out_tready,
  output logic [sqs_pkg::OUT_TDATA_W-1:0]         out_tdata
);

  localparam int PAT_AW = sqs_pkg::PAT_AW;
  localparam int TXT_AW = sqs_pkg::TXT_AW;
  localparam int PLEN_W = sqs_pkg::PLEN_W;
  localparam int TLEN_W = sqs_pkg::TLEN_W;
  localparam int SYM_W  = sqs_pkg::SYM_W;
  localparam int CNT_W  = sqs_pkg::CNT_W;
  localparam int POS_W  = sqs_pkg::POS_W;

  logic [SYM_W-1:0]  pat_mem [sqs_pkg::PATTERN_MAX];
  logic [SYM_W-1:0]  txt_mem [sqs_pkg::TEXT_MAX];
  logic [PAT_AW-1:0] lo_mem  [sqs_pkg::ALPHA];
  logic [sqs_pkg::ALPHA-1:0] vld_r;

  logic [PLEN_W-1:0] plen_r;
  logic [TLEN_W-1:0] tlen_r;
  logic [TLEN_W-1:0] pos_r;
  logic [TLEN_W-1:0] pos_nxt;
  logic [TLEN_W-1:0] past_r;
  logic              past_ok_r;
  logic [PAT_AW-1:0] k_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [CNT_W-1:0]  cnt_nxt;
  logic              ovf_r;
  logic              hit_r;
  logic [TLEN_W-1:0] hit_pos_r;

  logic [SYM_W-1:0]  pat_rd_r;
  logic [SYM_W-1:0]  txt_rd_r;
  logic [PAT_AW-1:0] lo_rd_r;
  logic              vld_rd_r;

  logic              out_valid_r;
  logic              out_valid_nxt;
  logic [sqs_pkg::OUT_W-1:0] out_data_r;

  logic [PAT_AW-1:0] ridx;
  logic [TLEN_W-1:0] cmp_addr;
  logic [TXT_AW-1:0] txt_ra;
  logic [TLEN_W-1:0] past_sum;
  logic              pat_room;
  logic              txt_room;

  assign pat_room = plen_r < PLEN_W'(sqs_pkg::PATTERN_MAX);
  assign txt_room = tlen_r < TLEN_W'(sqs_pkg::TEXT_MAX);

  // Index of the pattern byte fetched this cycle; data arrives next cycle.
  assign ridx     = cmd.fetch_first ? '0 : k_r + 1'b1;
  assign cmp_addr = pos_r + TLEN_W'(ridx);
  assign past_sum = pos_r + TLEN_W'(plen_r);
  assign txt_ra   = cmd.fetch_past ? past_r[TXT_AW-1:0] : cmp_addr[TXT_AW-1:0];

  // The past-window fetch addresses the text store with past_sum, as past_r is loaded by the same command.
  logic [TXT_AW-1:0] txt_addr;
  assign txt_addr = cmd.fetch_past ? past_sum[TXT_AW-1:0] : txt_ra;

  assign stat.win_ok   = (plen_r != '0) && (past_sum <= tlen_r);
  assign stat.eq       = (pat_rd_r == txt_rd_r);
  assign stat.last     = ({1'b0, k_r} == (plen_r - 1'b1));
  assign stat.hit      = hit_r;
  assign stat.out_free = !out_valid_r || out_tready;

  assign cnt_nxt = (cnt_r == {CNT_W{1'b1}}) ? cnt_r : cnt_r + 1'b1;

  // Sunday shift: align the byte past the window with its last occurrence.
  assign pos_nxt = (past_ok_r && vld_rd_r) ? past_r - TLEN_W'(lo_rd_r)
                                           : past_r + 1'b1;

  assign out_valid_nxt = cmd.emit ? 1'b1 : (out_tready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (cmd.app_pat && pat_room) begin
      pat_mem[plen_r[PAT_AW-1:0]] <= symbol;
    end
    pat_rd_r <= pat_mem[ridx];
  end

  always_ff @(posedge clk) begin
    if (cmd.app_txt && txt_room) begin
      txt_mem[tlen_r[TXT_AW-1:0]] <= symbol;
    end
    txt_rd_r <= txt_mem[txt_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.app_pat && pat_room) begin
      lo_mem[symbol] <= plen_r[PAT_AW-1:0];
    end
    lo_rd_r  <= lo_mem[txt_rd_r];
    vld_rd_r <= vld_r[txt_rd_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      plen_r      <= '0;
      tlen_r      <= '0;
      pos_r       <= '0;
      cnt_r       <= '0;
      ovf_r       <= 1'b0;
      hit_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (cmd.clear) begin
        vld_r  <= '0;
        plen_r <= '0;
        tlen_r <= '0;
        pos_r  <= '0;
        cnt_r  <= '0;
        ovf_r  <= 1'b0;
      end
      if (cmd.app_pat) begin
        if (pat_room) begin
          plen_r        <= plen_r + 1'b1;
          vld_r[symbol] <= 1'b1;
        end else begin
          ovf_r <= 1'b1;
        end
      end
      if (cmd.app_txt) begin
        if (txt_room) begin
          tlen_r <= tlen_r + 1'b1;
        end else begin
          ovf_r <= 1'b1;
        end
      end
      if (cmd.find) begin
        hit_r <= 1'b0;
      end
      if (cmd.check) begin
        cnt_r <= cnt_nxt;
        if (stat.eq && stat.last) begin
          hit_r <= 1'b1;
        end
      end
      if (cmd.shift) begin
        pos_r <= pos_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fetch_first) begin
      k_r <= '0;
    end else if (cmd.fetch_next) begin
      k_r <= k_r + 1'b1;
    end
    if (cmd.check) begin
      hit_pos_r <= pos_r;
    end
    if (cmd.fetch_past) begin
      past_r    <= past_sum;
      past_ok_r <= past_sum < tlen_r;
    end
    if (cmd.emit) begin
      out_data_r <= {ovf_r, cnt_r, !hit_r,
                     hit_r ? hit_pos_r[POS_W-1:0] : {POS_W{1'b0}}, hit_r};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(sqs_pkg::OUT_TDATA_W - sqs_pkg::OUT_W){1'b0}}, out_data_r};

endmodule
`default_nettype wire

/* rtl/core/sunday_quick_search_matcher.sv */
// Top level of the Sunday quick search matcher: controller plus datapath.
//
//  Channel | Direction | Handshake           | Contents
//  in      | input     | in_tvalid/in_tready | tuser: op; tdata: symbol
//  out     | output    | out_tvalid/out_tready | tdata: found, position, done_res,
//          |           |                     |   compare_count, overflowed
//
// A clear, pattern append or text append word is taken while the controller
// is idle, and the next word may follow at once. A find word starts a search
// run by the controller: each window passes through the window test, the
// first fetch, the byte comparisons one by one, the shift lookup (text port,
// then table port) and the shift, and the run ends with the closing window
// test and the load of the result register.
// Reset (rst_n low, synchronous) empties the stores' lengths, the occurrence
// valid bits, the count and the overflow flag. A result waits in its output
// register while out_tready is low; no new word is taken until it is loaded.
`default_nettype none
module sunday_quick_search_matcher (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_tvalid,
  output logic                                    in_tready,
  // in_tdata: [7:0] symbol
  input  wire logic [sqs_pkg::SYM_W-1:0]          in_tdata,
  // in_tuser: [1:0] op
  input  wire logic [sqs_pkg::OP_W-1:0]           in_tuser,
  output logic                                    out_tvalid,
  input  wire logic                               out_tready,
  // out_tdata: [0] found, [12:1] position, [13] done_res,
  // [32:14] compare_count, [33] overflowed, [39:34] zero
  output logic [sqs_pkg::OUT_TDATA_W-1:0]         out_tdata
);

  sqs_pkg::cmd_t  cmd;
  sqs_pkg::stat_t stat;

  // The controller sequences windows and comparisons; the datapath owns the
  // pattern, text and last-occurrence memories.
  sqs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .op        (in_tuser),
    .stat      (stat),
    .cmd       (cmd)
  );

  sqs_dpath u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .symbol     (in_tdata),
    .cmd        (cmd),
    .stat       (stat),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule
`default_nettype wire

/* dv/tb.sv */
// Self-checking testbench for the Sunday quick search matcher stream block.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sqs_pkg::*;

  // Largest value the comparison counter can hold before it saturates.
  localparam int unsigned COUNT_CEIL = (1 << CNT_W) - 1;

  // Number of input words the random part aims for.
  localparam int unsigned RANDOM_WORDS = 1250;

  // Words accepted per handshake phase before the next phase starts.
  localparam int unsigned PHASE_WORDS = 320;

  // One find answer, as carried in out_tdata.
  typedef struct packed {
    logic             found;
    logic [POS_W-1:0] pos;
    logic             done;
    logic [CNT_W-1:0] count;
    logic             ovf;
  } find_answer_t;

  // One row of the directed plan: a word repeated reps times, and, for rows
  // whose answer is obvious, the answer typed in by hand.
  typedef struct {
    op_t              op;
    logic [SYM_W-1:0] sym;
    int unsigned      reps;
    bit               typed;
    find_answer_t     want;
  } plan_row_t;

  logic clk;
  logic rst_n = 1'b0;

  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [SYM_W-1:0]       in_tdata  = '0;
  logic [OP_W-1:0]        in_tuser  = OP_CLEAR;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;

  sunday_quick_search_matcher uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // Free-running 100 MHz clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Matcher mirror. It keeps its own copy of the stores, the occurrence table
  // and the search state, and is advanced once for every accepted word.
  // ---------------------------------------------------------------------------
  logic [SYM_W-1:0]  pat_bytes [PATTERN_MAX];
  logic [SYM_W-1:0]  txt_bytes [TEXT_MAX];
  logic [PAT_AW-1:0] last_seen_at [ALPHA];
  bit                seen_in_pat  [ALPHA];
  int unsigned       pat_len;
  int unsigned       txt_len;
  int unsigned       scan_pos;
  int unsigned       compares_done;
  bit                dropped_append;

  // Find answers still owed by the block, oldest first.
  find_answer_t find_answers [$];

  int unsigned errors;
  int unsigned words_sent;
  int unsigned answers_checked;
  int unsigned hits_seen;

  // A clear word and reset both land here. The stores keep their bytes, but
  // nothing below the zeroed lengths can be read again until rewritten.
  function automatic void wipe_matcher();
    foreach (seen_in_pat[i]) seen_in_pat[i] = 1'b0;
    pat_len        = 0;
    txt_len        = 0;
    scan_pos       = 0;
    compares_done  = 0;
    dropped_append = 1'b0;
  endfunction

  // Runs the quick search from the kept position until the next hit or
  // until no window fits. Every byte comparison bumps the saturating count.
  function automatic find_answer_t search_next_hit();
    find_answer_t ans;
    int unsigned  here;
    int unsigned  past;
    bit           hit;
    ans = '{found: 1'b0, pos: '0, done: 1'b1, count: '0, ovf: 1'b0};
    // An empty pattern, or one longer than the text, ends at once with no
    // comparisons at all.
    if (pat_len != 0 && pat_len <= txt_len) begin
      while (scan_pos + pat_len <= txt_len) begin
        here = scan_pos;
        hit  = 1'b1;
        for (int unsigned k = 0; k < pat_len; k++) begin
          if (compares_done < COUNT_CEIL) compares_done++;
          if (pat_bytes[k] != txt_bytes[here + k]) begin
            hit = 1'b0;
            break;
          end
        end
        // Shift on the byte just past the window. A byte missing from the
        // pattern, or no byte at all past the last window, skips length + 1.
        past = here + pat_len;
        if (past < txt_len && seen_in_pat[txt_bytes[past]]) begin
          scan_pos = past - last_seen_at[txt_bytes[past]];
        end else begin
          scan_pos = past + 1;
        end
        if (hit) begin
          ans.found = 1'b1;
          ans.pos   = here[POS_W-1:0];
          ans.done  = 1'b0;
          break;
        end
      end
    end
    ans.count = compares_done[CNT_W-1:0];
    ans.ovf   = dropped_append;
    return ans;
  endfunction

  // Applies one accepted word to the mirror. Returns 1 when the word owes an
  // answer, which is then left in ans.
  function automatic bit apply_word(input op_t op, input logic [SYM_W-1:0] sym,
                                    output find_answer_t ans);
    ans = '0;
    case (op)
      OP_CLEAR: begin
        wipe_matcher();
        return 1'b0;
      end
      OP_APP_PAT: begin
        if (pat_len < PATTERN_MAX) begin
          pat_bytes[pat_len] = sym;
          last_seen_at[sym]  = pat_len[PAT_AW-1:0];
          seen_in_pat[sym]   = 1'b1;
          pat_len++;
        end else begin
          dropped_append = 1'b1;
        end
        return 1'b0;
      end
      OP_APP_TXT: begin
        if (txt_len < TEXT_MAX) begin
          txt_bytes[txt_len] = sym;
          txt_len++;
        end else begin
          dropped_append = 1'b1;
        end
        return 1'b0;
      end
      default: begin
        ans = search_next_hit();
        return 1'b1;
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Handshake pressure. The run walks through four phases by word count:
  // no idling, sender idle with a chance of 54 percent, receiver stalled with a
  // chance of 54 percent, and both idling with a chance of 33 percent.
  // ---------------------------------------------------------------------------
  function automatic bit take_gap(input bit sender_side);
    int unsigned ph;
    int unsigned pct;
    ph  = (words_sent / PHASE_WORDS) % 4;
    pct = 0;
    if (ph == 3) begin
      pct = 33;
    end else if ((ph == 1 && sender_side) || (ph == 2 && !sender_side)) begin
      pct = 54;
    end
    return $urandom_range(99) < pct;
  endfunction

  // Receiver side: out_tready is redrawn at every falling edge.
  always @(negedge clk) begin
    out_tready <= !take_gap(1'b0);
  end

  // Sends one word and waits until the block takes it. Inputs change only at
  // falling edges; the handshake is seen at the rising edge. When a word has
  // an answer, the answer is queued at the very edge that accepts the word.
  task automatic send_word(input op_t op, input logic [SYM_W-1:0] sym,
                           input bit typed, input find_answer_t typed_ans);
    find_answer_t ans;
    @(negedge clk);
    while (take_gap(1'b1)) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= sym;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    words_sent++;
    if (apply_word(op, sym, ans)) begin
      // A hand-typed answer replaces the mirror's, but the mirror still has
      // to see the word so that its state stays in step.
      find_answers.insert(find_answers.size(), typed ? typed_ans : ans);
    end
  endtask

  task automatic send_plain(input op_t op, input logic [SYM_W-1:0] sym);
    send_word(op, sym, 1'b0, '0);
  endtask

  // ---------------------------------------------------------------------------
  // Answer checking at the rising edge.
  // ---------------------------------------------------------------------------
  find_answer_t want_ans;
  find_answer_t got_ans;

  function automatic void check_field(input string name, input longint unsigned want,
                                      input longint unsigned got);
    if (want != got) begin
      errors++;
      $display("%0t: mismatch on %s, expected 0x%0h, actual 0x%0h", $time, name, want, got);
    end
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      got_ans = '{found: out_tdata[0], pos: out_tdata[12:1], done: out_tdata[13],
                  count: out_tdata[32:14], ovf: out_tdata[33]};
      if (find_answers.size() == 0) begin
        errors++;
        $display("%0t: answer word with none expected, actual 0x%0h", $time, out_tdata);
      end else begin
        want_ans = find_answers.pop_front();
        answers_checked++;
        if (got_ans.found) hits_seen++;
        check_field("found", want_ans.found, got_ans.found);
        check_field("position", want_ans.pos, got_ans.pos);
        check_field("done_res", want_ans.done, got_ans.done);
        check_field("compare_count", want_ans.count, got_ans.count);
        check_field("overflowed", want_ans.ovf, got_ans.ovf);
        check_field("padding", 0, out_tdata[OUT_TDATA_W-1:OUT_W]);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Directed plan. The run of 0xFF text bytes ends with the only byte the
  // pattern holds, so the hit sits at the last text index. The 65 pattern
  // bytes overflow the pattern store.
  // ---------------------------------------------------------------------------
  plan_row_t plan [$];

  function automatic void add_row(input op_t op, input logic [SYM_W-1:0] sym,
                                  input int unsigned reps, input bit typed,
                                  input find_answer_t want);
    plan_row_t row;
    row.op    = op;
    row.sym   = sym;
    row.reps  = reps;
    row.typed = typed;
    row.want  = want;
    plan.insert(plan.size(), row);
  endfunction

  task automatic run_plan();
    find_answer_t none_yet;
    find_answer_t none_ovf;
    none_yet = '{found: 1'b0, pos: '0, done: 1'b1, count: '0, ovf: 1'b0};
    none_ovf = '{found: 1'b0, pos: '0, done: 1'b1, count: '0, ovf: 1'b1};
    // Find straight after reset: nothing loaded, nothing counted.
    add_row(OP_FIND,    8'h00, 1,    1'b1, none_yet);
    add_row(OP_APP_PAT, 8'h00, 1,    1'b0, '0);
    // Pattern longer than the (empty) text.
    add_row(OP_FIND,    8'h00, 1,    1'b1, none_yet);
    add_row(OP_APP_TXT, 8'hFF, 31,   1'b0, '0);
    add_row(OP_APP_TXT, 8'h00, 1,    1'b0, '0);
    add_row(OP_FIND,    8'hFF, 1,    1'b0, '0);
    add_row(OP_FIND,    8'h00, 1,    1'b0, '0);
    // Clear ignores its byte and drops the sticky flag and the count.
    add_row(OP_CLEAR,   8'h5A, 1,    1'b0, '0);
    add_row(OP_FIND,    8'hA5, 1,    1'b1, none_yet);
    add_row(OP_APP_PAT, 8'h80, 65,   1'b0, '0);
    add_row(OP_FIND,    8'h7F, 1,    1'b1, none_ovf);
    add_row(OP_CLEAR,   8'h00, 1,    1'b0, '0);
    // Pattern ABA over text ABABA: overlapping hits at 0 and 2, then done.
    add_row(OP_APP_PAT, 8'h41, 1,    1'b0, '0);
    add_row(OP_APP_PAT, 8'h42, 1,    1'b0, '0);
    add_row(OP_APP_PAT, 8'h41, 1,    1'b0, '0);
    add_row(OP_APP_TXT, 8'h41, 1,    1'b0, '0);
    add_row(OP_APP_TXT, 8'h42, 1,    1'b0, '0);
    add_row(OP_APP_TXT, 8'h41, 1,    1'b0, '0);
    add_row(OP_APP_TXT, 8'h42, 1,    1'b0, '0);
    add_row(OP_APP_TXT, 8'h41, 1,    1'b0, '0);
    add_row(OP_FIND,    8'h00, 1,    1'b0, '0);
    add_row(OP_FIND,    8'h00, 1,    1'b0, '0);
    add_row(OP_FIND,    8'h00, 1,    1'b0, '0);
    foreach (plan[r]) begin
      for (int unsigned n = 0; n < plan[r].reps; n++) begin
        send_word(plan[r].op, plan[r].sym, plan[r].typed, plan[r].want);
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Random sessions. Most are well formed: clear, a short pattern and a text
  // drawn from a tiny alphabet so that hits are common, then a few finds,
  // sometimes with more text or pattern bytes slipped in between them. The
  // rest are bursts of arbitrary words.
  // ---------------------------------------------------------------------------
  task automatic run_sessions(input int unsigned target);
    logic [SYM_W-1:0] base;
    logic [SYM_W-1:0] txt_q [$];
    logic [SYM_W-1:0] pat_q [$];
    int unsigned      alpha;
    int unsigned      tlen;
    int unsigned      plen;
    int unsigned      start;
    int unsigned      finds;
    int unsigned      roll;
    target += words_sent;
    while (words_sent < target) begin
      if ($urandom_range(99) < 82) begin
        base  = $urandom_range(255);
        alpha = $urandom_range(1, 4);
        roll  = $urandom_range(99);
        tlen  = (roll < 8) ? $urandom_range(65, 96) : $urandom_range(0, 48);
        roll  = $urandom_range(99);
        if (roll < 3) begin
          plen = $urandom_range(60, 66);
        end else if (roll < 15) begin
          plen = $urandom_range(5, 12);
        end else begin
          plen = $urandom_range(1, 4);
        end
        txt_q.delete();
        pat_q.delete();
        for (int unsigned i = 0; i < tlen; i++) begin
          txt_q.insert(txt_q.size(), SYM_W'(base + $urandom_range(alpha - 1)));
        end
        // Often cut the pattern out of the text so that a hit is certain.
        if (plen <= tlen && $urandom_range(99) < 60) begin
          start = $urandom_range(tlen - plen);
          for (int unsigned i = 0; i < plen; i++) pat_q.insert(pat_q.size(), txt_q[start + i]);
        end else begin
          for (int unsigned i = 0; i < plen; i++) begin
            pat_q.insert(pat_q.size(), SYM_W'(base + $urandom_range(alpha - 1)));
          end
        end
        send_plain(OP_CLEAR, SYM_W'($urandom_range(255)));
        if ($urandom_range(1)) begin
          foreach (pat_q[i]) send_plain(OP_APP_PAT, pat_q[i]);
          foreach (txt_q[i]) send_plain(OP_APP_TXT, txt_q[i]);
        end else begin
          foreach (txt_q[i]) send_plain(OP_APP_TXT, txt_q[i]);
          foreach (pat_q[i]) send_plain(OP_APP_PAT, pat_q[i]);
        end
        finds = $urandom_range(1, 5);
        for (int unsigned f = 0; f < finds; f++) begin
          send_plain(OP_FIND, SYM_W'($urandom_range(255)));
          // Growing the text or pattern mid-search must resume from the kept
          // position rather than start over.
          roll = $urandom_range(99);
          if (roll < 10) begin
            for (int unsigned i = $urandom_range(1, 6); i > 0; i--) begin
              send_plain(OP_APP_TXT, SYM_W'(base + $urandom_range(alpha - 1)));
            end
          end else if (roll < 14) begin
            send_plain(OP_APP_PAT, SYM_W'(base + $urandom_range(alpha - 1)));
          end
        end
      end else begin
        for (int unsigned i = $urandom_range(1, 6); i > 0; i--) begin
          send_plain(op_t'($urandom_range(3)), SYM_W'($urandom_range(255)));
        end
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence.
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned plan_words;
    errors          = 0;
    words_sent      = 0;
    answers_checked = 0;
    hits_seen       = 0;
    wipe_matcher();

    // Synchronous reset, released at a falling edge.
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    run_plan();
    plan_words = words_sent;
    run_sessions(RANDOM_WORDS);

    @(negedge clk);
    in_tvalid <= 1'b0;

    // Drain the owed answers, then give the block time to show any stray
    // answer word.
    while (find_answers.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);

    $display("Sent %0d words (%0d directed) and checked %0d find answers, %0d of them hits,",
             words_sent, plan_words, answers_checked, hits_seen);
    $display("across no-idle, sender-idle, receiver-stall and mixed handshake phases.");
    if (errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #10ms;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
